[rtl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define ULA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ULA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ula_pkg.sv]
// ----------------------------------------------------------------------------
// ula_pkg
// Types and codes for the undo log array: operation kinds, undo record tags,
// status codes and the transfer structs of the command and result ports.
// ----------------------------------------------------------------------------
`default_nettype none

package ula_pkg;

  localparam int ARRAY_DEPTH_DEF = 1024;
  localparam int UNDO_DEPTH_DEF  = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // operation kinds
  localparam logic [2:0] KIND_PUSH  = 3'd0;
  localparam logic [2:0] KIND_POP   = 3'd1;
  localparam logic [2:0] KIND_SET   = 3'd2;
  localparam logic [2:0] KIND_UNDO  = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // undo record tags
  localparam logic [1:0] TAG_PUSH = 2'd0;
  localparam logic [1:0] TAG_POP  = 2'd1;
  localparam logic [1:0] TAG_SET  = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_LOGFULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTYLOG = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  index;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [10:0] length;
    logic        can_undo;
    logic [1:0]  status;
  } out_t;

endpackage

`default_nettype wire

[rtl/ula_ram.sv]
// ----------------------------------------------------------------------------
// ula_ram
// Single-clock memory, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ula_ram #(
  parameter int DEPTH = ula_pkg::ARRAY_DEPTH_DEF,
  parameter int WIDTH = ula_pkg::VALUE_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/ula_ctrl.sv]
// ----------------------------------------------------------------------------
// ula_ctrl
// Sequencer of the undo log array: issues memory reads on command transfer,
// then decides, writes back to the memories as the command requires and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ula_ctrl #(
  parameter int ARRAY_DEPTH = ula_pkg::ARRAY_DEPTH_DEF,
  parameter int UNDO_DEPTH  = ula_pkg::UNDO_DEPTH_DEF,
  parameter int VALUE_WIDTH = ula_pkg::VALUE_WIDTH_DEF,
  localparam int AW   = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1,
  localparam int UAW  = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1,
  localparam int RW   = 2 + AW + VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire ula_pkg::in_t           in_data,
  output logic                        out_valid,
  output ula_pkg::out_t               out_data,
  // element store
  output logic                        e_we,
  output logic      [AW-1:0]          e_waddr,
  output logic      [VALUE_WIDTH-1:0] e_wdata,
  output logic                        e_re,
  output logic      [AW-1:0]          e_raddr,
  input  wire logic [VALUE_WIDTH-1:0] e_rdata,
  // undo log
  output logic                        u_we,
  output logic      [UAW-1:0]         u_waddr,
  output logic      [RW-1:0]          u_wdata,
  output logic                        u_re,
  output logic      [UAW-1:0]         u_raddr,
  input  wire logic [RW-1:0]          u_rdata
);

  localparam int CW   = $clog2(ARRAY_DEPTH + 1);
  localparam int UCW  = $clog2(UNDO_DEPTH + 1);
  localparam int CMPW = (CW > 10) ? CW : 10;
  localparam int VW   = VALUE_WIDTH;

  localparam logic [CW-1:0]  AD_CNT = CW'(ARRAY_DEPTH);
  localparam logic [UCW-1:0] UD_CNT = UCW'(UNDO_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic           state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [UCW-1:0] ucount_r, ucount_nxt;
  logic [2:0]     kind_r;
  logic [9:0]     idx_r;
  logic [VW-1:0]  val_r;

  logic           out_valid_r;
  ula_pkg::out_t  out_data_r, res_nxt;

  logic           accept;
  logic [63:0]    in_val64;
  logic [63:0]    rd64;
  logic [VW-1:0]  rd;
  logic [1:0]     st;
  logic           log_full;
  logic           idx_ok;
  logic [AW-1:0]  idx_a;
  logic [1:0]     rec_tag;
  logic [AW-1:0]  rec_pos;
  logic [VW-1:0]  rec_old;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r == S_EXEC);
  assign in_val64 = 64'(in_data.value);

  // reads are issued at the command transfer, data is ready in the exec cycle
  assign e_re    = accept;
  assign e_raddr = (in_data.kind == ula_pkg::KIND_POP) ? AW'(count_r - 1'b1)
                                                       : AW'(in_data.index);
  assign u_re    = accept;
  assign u_raddr = UAW'(ucount_r - 1'b1);

  assign log_full = (ucount_r == UD_CNT);
  assign idx_ok   = CMPW'(idx_r) < CMPW'(count_r);
  assign idx_a    = AW'(idx_r);
  assign rec_tag  = u_rdata[RW-1 -: 2];
  assign rec_pos  = u_rdata[VW +: AW];
  assign rec_old  = u_rdata[VW-1:0];

  always_comb begin
    count_nxt  = count_r;
    ucount_nxt = ucount_r;
    st         = ula_pkg::STAT_OK;
    rd         = '0;
    e_we       = 1'b0;
    e_waddr    = AW'(count_r);
    e_wdata    = val_r;
    u_we       = 1'b0;
    u_waddr    = UAW'(ucount_r);
    u_wdata    = {ula_pkg::TAG_PUSH, {AW{1'b0}}, {VW{1'b0}}};

    if (state_r == S_EXEC) begin
      unique case (kind_r)
        ula_pkg::KIND_PUSH: begin
          if (count_r == AD_CNT) begin
            st = ula_pkg::STAT_RANGE;
          end else if (log_full) begin
            st = ula_pkg::STAT_LOGFULL;
          end else begin
            u_we       = 1'b1;
            ucount_nxt = ucount_r + 1'b1;
            e_we       = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end
        ula_pkg::KIND_POP: begin
          if (count_r == '0) begin
            st = ula_pkg::STAT_RANGE;
          end else if (log_full) begin
            st = ula_pkg::STAT_LOGFULL;
          end else begin
            u_we       = 1'b1;
            u_wdata    = {ula_pkg::TAG_POP, {AW{1'b0}}, e_rdata};
            ucount_nxt = ucount_r + 1'b1;
            count_nxt  = count_r - 1'b1;
          end
        end
        ula_pkg::KIND_SET: begin
          if (!idx_ok) begin
            st = ula_pkg::STAT_RANGE;
          end else if (log_full) begin
            st = ula_pkg::STAT_LOGFULL;
          end else begin
            u_we       = 1'b1;
            u_wdata    = {ula_pkg::TAG_SET, idx_a, e_rdata};
            ucount_nxt = ucount_r + 1'b1;
            e_we       = 1'b1;
            e_waddr    = idx_a;
          end
        end
        ula_pkg::KIND_UNDO: begin
          if (ucount_r == '0) begin
            st = ula_pkg::STAT_EMPTYLOG;
          end else if (rec_tag == ula_pkg::TAG_SET) begin
            if (CW'(rec_pos) >= count_r) begin
              st = ula_pkg::STAT_RANGE;
            end else begin
              e_we       = 1'b1;
              e_waddr    = rec_pos;
              e_wdata    = rec_old;
              ucount_nxt = ucount_r - 1'b1;
            end
          end else if (rec_tag == ula_pkg::TAG_PUSH) begin
            if (count_r == '0) begin
              st = ula_pkg::STAT_RANGE;
            end else begin
              count_nxt  = count_r - 1'b1;
              ucount_nxt = ucount_r - 1'b1;
            end
          end else begin
            // re-append the popped value
            if (count_r == AD_CNT) begin
              st = ula_pkg::STAT_RANGE;
            end else begin
              e_we       = 1'b1;
              e_wdata    = rec_old;
              count_nxt  = count_r + 1'b1;
              ucount_nxt = ucount_r - 1'b1;
            end
          end
        end
        ula_pkg::KIND_READ: begin
          if (!idx_ok) begin
            st = ula_pkg::STAT_RANGE;
          end else begin
            rd = e_rdata;
          end
        end
        default: begin
          st = ula_pkg::STAT_RANGE;
        end
      endcase
    end
  end

  assign rd64 = 64'(rd);

  always_comb begin
    res_nxt.read_value = rd64[31:0];
    res_nxt.length     = 11'(count_nxt);
    res_nxt.can_undo   = (ucount_nxt != '0);
    res_nxt.status     = st;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ucount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ucount_r    <= ucount_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_data.kind;
      idx_r  <= in_data.index;
      val_r  <= in_val64[VW-1:0];
    end
    if (state_r == S_EXEC) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/undo_log_array_top.sv]
// timing: a command transferred at a clock edge is decided in the exec state,
// and its result is registered at the end of that state and strobed on out_valid
// busy: the block takes no new command while in the exec state, which holds the
// write-back of the element store and undo log memories
// reset: element and undo counts clear to zero; memory contents are not cleared
// ----------------------------------------------------------------------------
// undo_log_array_top
// Growable array with an undo log: push, pop, overwrite, undo and read.
// ----------------------------------------------------------------------------
`default_nettype none

module undo_log_array_top #(
  parameter int ARRAY_DEPTH = ula_pkg::ARRAY_DEPTH_DEF,
  parameter int UNDO_DEPTH  = ula_pkg::UNDO_DEPTH_DEF,
  parameter int VALUE_WIDTH = ula_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire ula_pkg::in_t  in_data,
  output logic               out_valid,
  output ula_pkg::out_t      out_data
);

  localparam int AW  = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int UAW = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
  localparam int RW  = 2 + AW + VALUE_WIDTH;

  logic                   e_we, e_re;
  logic [AW-1:0]          e_waddr, e_raddr;
  logic [VALUE_WIDTH-1:0] e_wdata, e_rdata;
  logic                   u_we, u_re;
  logic [UAW-1:0]         u_waddr, u_raddr;
  logic [RW-1:0]          u_wdata, u_rdata;

  ula_ctrl #(
    .ARRAY_DEPTH (ARRAY_DEPTH),
    .UNDO_DEPTH  (UNDO_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .e_we      (e_we),
    .e_waddr   (e_waddr),
    .e_wdata   (e_wdata),
    .e_re      (e_re),
    .e_raddr   (e_raddr),
    .e_rdata   (e_rdata),
    .u_we      (u_we),
    .u_waddr   (u_waddr),
    .u_wdata   (u_wdata),
    .u_re      (u_re),
    .u_raddr   (u_raddr),
    .u_rdata   (u_rdata)
  );

  ula_ram #(
    .DEPTH (ARRAY_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  ula_ram #(
    .DEPTH (UNDO_DEPTH),
    .WIDTH (RW)
  ) u_log_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .re    (u_re),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

endmodule

`default_nettype wire

[rtl/ula_checker.sv]
// ----------------------------------------------------------------------------
// ula_checker
// Port-level checks of the undo log array, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ula_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire ula_pkg::out_t out_data
);

  logic in_xfer;
  logic elog_res;
  logic flog_res;

  assign in_xfer  = start && !busy;
  assign elog_res = out_valid && (out_data.status == ula_pkg::STAT_EMPTYLOG);
  assign flog_res = out_valid && (out_data.status == ula_pkg::STAT_LOGFULL);

  // every transfer gets its result strobe after the exec state
  `ULA_ASSERT(a_result_follows, clk, rst_n, in_xfer |=> ##1 out_valid, "result missing")
  // result strobes never come back to back
  `ULA_ASSERT(a_single_strobe, clk, rst_n, out_valid |=> !out_valid, "strobe too long")
  // an empty log cannot report undo available
  `ULA_ASSERT(a_elog_no_undo, clk, rst_n, elog_res |-> !out_data.can_undo, "can_undo on empty log")
  // a full log holds records
  `ULA_ASSERT(a_flog_undo, clk, rst_n, flog_res |-> out_data.can_undo, "full log, no records")
  // reset leaves the block idle
  `ULA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule

bind undo_log_array_top ula_checker u_ula_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

[tb/sv/tb_undo_log_array_top.sv]
// ----------------------------------------------------------------------------
// tb_undo_log_array_top
// Self-checking bench for the undo log array. Commands are driven with random
// burst gaps. A local copy of the element store and the undo log predicts
// every result, and each strobed result is checked field by field against the
// oldest prediction. Tests cover the error cases, filling both stores and a
// random mix of operations.
// ----------------------------------------------------------------------------

module tb_undo_log_array_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARR_DEPTH   = ula_pkg::ARRAY_DEPTH_DEF;
  localparam int LOG_DEPTH   = ula_pkg::UNDO_DEPTH_DEF;
  localparam int IDLE_LIMIT  = 500;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [1:0]  tag;
    logic [9:0]  pos;
    logic [31:0] old;
  } undo_rec_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  ula_pkg::in_t  in_data = '0;
  logic          busy;
  logic          out_valid;
  ula_pkg::out_t out_data;

  // shadow copy of the block state
  logic [31:0] elem_mem [ARR_DEPTH];
  int          elem_cnt = 0;
  undo_rec_t   rec_mem [LOG_DEPTH];
  int          rec_cnt = 0;

  ula_pkg::out_t pending_results[$];
  int            err_cnt = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;

  always #2 clk = ~clk;

  undo_log_array_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // applies one command to the shadow state and returns its result
  function automatic ula_pkg::out_t step_array(ula_pkg::in_t op);
    ula_pkg::out_t res;
    logic [1:0]    st;
    undo_rec_t     top;
    res = '0;
    st  = ula_pkg::STAT_OK;
    case (op.kind)
      ula_pkg::KIND_PUSH: begin
        if (elem_cnt >= ARR_DEPTH) st = ula_pkg::STAT_RANGE;
        else if (rec_cnt >= LOG_DEPTH) st = ula_pkg::STAT_LOGFULL;
        else begin
          rec_mem[rec_cnt] = '{ula_pkg::TAG_PUSH, 10'd0, 32'd0};
          rec_cnt++;
          elem_mem[elem_cnt] = op.value;
          elem_cnt++;
        end
      end
      ula_pkg::KIND_POP: begin
        if (elem_cnt == 0) st = ula_pkg::STAT_RANGE;
        else if (rec_cnt >= LOG_DEPTH) st = ula_pkg::STAT_LOGFULL;
        else begin
          rec_mem[rec_cnt] = '{ula_pkg::TAG_POP, 10'd0, elem_mem[elem_cnt-1]};
          rec_cnt++;
          elem_cnt--;
        end
      end
      ula_pkg::KIND_SET: begin
        if (int'(op.index) >= elem_cnt) st = ula_pkg::STAT_RANGE;
        else if (rec_cnt >= LOG_DEPTH) st = ula_pkg::STAT_LOGFULL;
        else begin
          rec_mem[rec_cnt] = '{ula_pkg::TAG_SET, op.index, elem_mem[op.index]};
          rec_cnt++;
          elem_mem[op.index] = op.value;
        end
      end
      ula_pkg::KIND_UNDO: begin
        if (rec_cnt == 0) st = ula_pkg::STAT_EMPTYLOG;
        else begin
          top = rec_mem[rec_cnt-1];
          case (top.tag)
            ula_pkg::TAG_SET: begin
              if (int'(top.pos) >= elem_cnt) st = ula_pkg::STAT_RANGE;
              else elem_mem[top.pos] = top.old;
            end
            ula_pkg::TAG_PUSH: begin
              if (elem_cnt == 0) st = ula_pkg::STAT_RANGE;
              else elem_cnt--;
            end
            default: begin
              if (elem_cnt >= ARR_DEPTH) st = ula_pkg::STAT_RANGE;
              else begin
                elem_mem[elem_cnt] = top.old;
                elem_cnt++;
              end
            end
          endcase
          // a record that cannot be applied stays on the log
          if (st == ula_pkg::STAT_OK) rec_cnt--;
        end
      end
      ula_pkg::KIND_READ: begin
        if (int'(op.index) >= elem_cnt) st = ula_pkg::STAT_RANGE;
        else res.read_value = elem_mem[op.index];
      end
      default: st = ula_pkg::STAT_RANGE;
    endcase
    res.length   = 11'(elem_cnt);
    res.can_undo = (rec_cnt != 0);
    res.status   = st;
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // result checking, command capture and watchdog
  always @(posedge clk) begin : monitor
    ula_pkg::out_t want;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected, actual 0x%0h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          compare_field("read_value", want.read_value, out_data.read_value);
          compare_field("length", 32'(want.length), 32'(out_data.length));
          compare_field("can_undo", 32'(want.can_undo), 32'(out_data.can_undo));
          compare_field("status", 32'(want.status), 32'(out_data.status));
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        pending_results.insert(pending_results.size(), step_array(in_data));
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // drives one command at the falling edge and returns after its transfer
  task automatic send_cmd(input logic [2:0] kind, input logic [9:0] index,
                          input logic [31:0] value);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    start   = 1'b1;
    in_data = '{kind, index, value};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] pick_index();
    if (elem_cnt > 0 && $urandom_range(0, 9) < 8) return 10'($urandom_range(0, elem_cnt - 1));
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic test_directed_ops();
    send_cmd(ula_pkg::KIND_UNDO, 10'd0, 32'd0);
    send_cmd(ula_pkg::KIND_POP, 10'd0, 32'd0);
    send_cmd(ula_pkg::KIND_READ, 10'd0, 32'd0);
    send_cmd(ula_pkg::KIND_SET, 10'd0, 32'h0bad_f00d);
    send_cmd(3'd5, 10'd0, 32'd0);
    send_cmd(3'd6, 10'h3ff, '1);
    send_cmd(3'd7, 10'd1, 32'd1);
    send_cmd(ula_pkg::KIND_PUSH, 10'h3ff, 32'd0);
    send_cmd(ula_pkg::KIND_PUSH, 10'd0, '1);
    send_cmd(ula_pkg::KIND_PUSH, 10'd0, 32'ha5a5_a5a5);
    send_cmd(ula_pkg::KIND_READ, 10'd0, 32'd0);
    send_cmd(ula_pkg::KIND_READ, 10'd1, 32'd0);
    send_cmd(ula_pkg::KIND_READ, 10'd2, 32'd0);
    send_cmd(ula_pkg::KIND_READ, 10'd3, 32'd0);
    send_cmd(ula_pkg::KIND_READ, 10'h3ff, 32'd0);
    send_cmd(ula_pkg::KIND_SET, 10'd1, 32'h1234_5678);
    send_cmd(ula_pkg::KIND_SET, 10'd3, 32'h5555_5555);
    send_cmd(ula_pkg::KIND_POP, 10'd0, 32'd0);
    send_cmd(ula_pkg::KIND_READ, 10'd1, 32'd0);
    // undo the pop, then the overwrite
    send_cmd(ula_pkg::KIND_UNDO, 10'd0, 32'd0);
    send_cmd(ula_pkg::KIND_UNDO, 10'd0, 32'd0);
    send_cmd(ula_pkg::KIND_READ, 10'd1, 32'd0);
    wait_results_done();
  endtask

  task automatic test_capacity_limits();
    while (elem_cnt < ARR_DEPTH && rec_cnt < LOG_DEPTH)
      send_cmd(ula_pkg::KIND_PUSH, pick_index(), pick_value());
    // array full and log full: array error wins
    send_cmd(ula_pkg::KIND_PUSH, 10'd0, 32'hdead_beef);
    send_cmd(ula_pkg::KIND_POP, 10'd0, 32'd0);
    send_cmd(ula_pkg::KIND_SET, pick_index(), pick_value());
    send_cmd(ula_pkg::KIND_READ, 10'(elem_cnt - 1), 32'd0);
    repeat (3) send_cmd(ula_pkg::KIND_UNDO, pick_index(), 32'd0);
    while (rec_cnt < LOG_DEPTH && elem_cnt > 0)
      send_cmd(ula_pkg::KIND_SET, pick_index(), pick_value());
    // log full with room in the array
    send_cmd(ula_pkg::KIND_PUSH, 10'd0, 32'h0f0f_0f0f);
    send_cmd(ula_pkg::KIND_SET, 10'h3ff, 32'd7);
    send_cmd(ula_pkg::KIND_READ, 10'h3ff, 32'd0);
    repeat (5) send_cmd(ula_pkg::KIND_UNDO, pick_index(), pick_value());
    wait_results_done();
  endtask

  task automatic random_phase(input int count, input int push_w, input int pop_w,
                              input int set_w, input int undo_w, input int read_w);
    int         roll;
    logic [2:0] kind;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_w) kind = ula_pkg::KIND_PUSH;
      else if (roll < push_w + pop_w) kind = ula_pkg::KIND_POP;
      else if (roll < push_w + pop_w + set_w) kind = ula_pkg::KIND_SET;
      else if (roll < push_w + pop_w + set_w + undo_w) kind = ula_pkg::KIND_UNDO;
      else if (roll < push_w + pop_w + set_w + undo_w + read_w) kind = ula_pkg::KIND_READ;
      else kind = 3'($urandom_range(5, 7));
      send_cmd(kind, pick_index(), pick_value());
    end
  endtask

  task automatic test_random_ops();
    // undo-heavy mix first, the log is close to full here
    random_phase(60, 8, 15, 12, 45, 12);
    // let everything settle before the next phase
    wait_results_done();
    random_phase(90, 25, 15, 20, 17, 20);
    wait_results_done();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_directed_ops();
    test_capacity_limits();
    test_random_ops();
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/ula_pkg.sv
rtl/ula_ram.sv
rtl/ula_ctrl.sv
rtl/undo_log_array_top.sv
rtl/ula_checker.sv
tb/sv/tb_undo_log_array_top.sv
